### sv/arxw_pkg.sv
// Package for the ARX counter random word unit: item type, rotation
// constants and the add-xor-rotate mixing step. No dependencies.
`default_nettype none

package arxw_pkg;

   localparam int unsigned WordWidth  = 64;
   localparam int unsigned BlockWords = 8;
   localparam int unsigned StepsPerRound = 4;

   typedef logic [WordWidth-1:0] word_type;

   // One item in flight: the 512-bit block and the word to pick at the end
   typedef struct packed {
      logic [BlockWords-1:0][WordWidth-1:0] words;
      logic [2:0]                           sel;
   } arxw_item_type;

   // Rotation pairs per step within a round, entry 0 is the step at base 0
   localparam logic [StepsPerRound-1:0][5:0] ROT_FIRST  = {6'd16, 6'd18, 6'd20, 6'd22};
   localparam logic [StepsPerRound-1:0][5:0] ROT_SECOND = {6'd49, 6'd41, 6'd43, 6'd45};

   function automatic word_type rotl(input word_type v, input logic [5:0] r);
      rotl = (v << r) | (v >> (7'd64 - {1'b0, r}));
   endfunction

   // One add-xor-rotate step at base word 2*step, indices wrap mod 8
   function automatic arxw_item_type mix_step(input arxw_item_type item,
                                              input logic [1:0] step);
      logic [2:0]    p0;
      logic [2:0]    p1;
      logic [2:0]    p2;
      logic [2:0]    p3;
      word_type      a2;
      word_type      a3;
      arxw_item_type res;
      p0  = {step, 1'b0};
      p1  = p0 + 3'd1;
      p2  = p0 + 3'd2;
      p3  = p0 + 3'd3;
      a2  = (item.words[p2] ^ item.words[p0]) + item.words[p1];
      a3  = (item.words[p3] ^ item.words[p1]) + item.words[p0];
      res = item;
      res.words[p2] = rotl(a2, ROT_FIRST[step]);
      res.words[p3] = rotl(a3, ROT_SECOND[step]);
      mix_step = res;
   endfunction

endpackage

`default_nettype wire

### sv/arxw_stage.sv
// One pipeline stage of the ARX random word unit: applies one mixing step
// and registers the item with its valid bit. Depends on arxw_pkg.
`default_nettype none

module arxw_stage #(
   parameter int unsigned STEP = 0
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      advance,
   input  wire                      in_valid,
   input  arxw_pkg::arxw_item_type  in_item,
   output logic                     out_valid,
   output arxw_pkg::arxw_item_type  out_item
);

   localparam logic [1:0] StepCode = STEP[1:0];

   logic                    valid_ff;
   arxw_pkg::arxw_item_type item_ff;
   arxw_pkg::arxw_item_type item_in;

   // mixing logic for this step
   always_comb begin
      item_in = arxw_pkg::mix_step(in_item, StepCode);
   end

   // valid bit, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // payload, loaded whenever the stage moves
   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

### sv/arx_counter_random_word_unit.sv
// Top level of the ARX counter random word unit: stage chain and output
// register. Depends on arxw_pkg and arxw_stage.
`default_nettype none

// Counter-based random word generator with random access. Each transfer on
// the req_ channel names a 64-bit stream position; the rsp_ channel returns
// the 64-bit word at that position. Requests may arrive in any order. The
// unit takes one request per cycle and delivers one word per cycle while
// rsp_stall is low. Each of the 4*NUM_ROUNDS pipeline stages performs one
// add-xor-rotate step (two 64-bit xor, add and fixed-rotate operations),
// and a final register selects the requested word. Empty stages fill in
// while the output is stalled, so bubbles are squeezed out.
module arx_counter_random_word_unit #(
   parameter int unsigned NUM_ROUNDS = 3
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [63:0] req_word_index,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_random_word
);

   localparam int unsigned NumStages = arxw_pkg::StepsPerRound * NUM_ROUNDS;

   arxw_pkg::arxw_item_type first_item;
   logic                    stage_valid [NumStages];
   arxw_pkg::arxw_item_type stage_item  [NumStages];
   logic                    stage_ready [NumStages];
   logic                    out_ready;
   logic                    rsp_valid_ff;
   logic [63:0]             rsp_random_word_ff;

   // initial block: word 0 = aligned index + 1, others zero
   always_comb begin
      first_item          = '0;
      first_item.words[0] = {req_word_index[63:3], 3'b000} + 64'd1;
      first_item.sel      = req_word_index[2:0];
   end

   // ready chain: a stage moves when it is empty or its successor moves
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stage_ready[NumStages-1] = !stage_valid[NumStages-1] || out_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
      end
   end

   assign req_stall = !stage_ready[0];

   // stage chain, one mixing step per stage
   for (genvar k = 0; k < NumStages; k++) begin : g_stage
      if (k == 0) begin : g_first
         arxw_stage #(.STEP(0)) u_stage (
            .clock     (clock),
            .reset     (reset),
            .advance   (stage_ready[0]),
            .in_valid  (req_valid),
            .in_item   (first_item),
            .out_valid (stage_valid[0]),
            .out_item  (stage_item[0])
         );
      end else begin : g_next
         arxw_stage #(.STEP(k % arxw_pkg::StepsPerRound)) u_stage (
            .clock     (clock),
            .reset     (reset),
            .advance   (stage_ready[k]),
            .in_valid  (stage_valid[k-1]),
            .in_item   (stage_item[k-1]),
            .out_valid (stage_valid[k]),
            .out_item  (stage_item[k])
         );
      end
   end

   // output register with word select
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= stage_valid[NumStages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_random_word_ff <=
            stage_item[NumStages-1].words[stage_item[NumStages-1].sel];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_random_word_ff;

   // accepted request lands in the first stage
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stage_valid[0])
      else $error("accepted request missing from first stage");

   // a free output never stalls the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   // a held last stage keeps its item
   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid[NumStages-1] && !stage_ready[NumStages-1]) |=>
         (stage_valid[NumStages-1] && $stable(stage_item[NumStages-1])))
      else $error("last stage lost or changed a held item");

   // a new response only comes from a valid last stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(stage_valid[NumStages-1]))
      else $error("response without a source item");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for arx_counter_random_word_unit: bursty requests,
// patterned output stalls, and an in-order scoreboard with a local predictor.
// Depends on arxw_pkg (word type) and the unit itself.
module tb;

   localparam int NumRounds  = 3;
   localparam int Latency    = 4 * NumRounds + 1;
   localparam int RandomReqs = 1800;
   localparam int CycleLimit = 400000;

   // Rotation amounts per mixing step, step 0 first
   localparam int RotLow[4]  = '{22, 20, 18, 16};
   localparam int RotHigh[4] = '{45, 43, 41, 49};

   // Corner positions: stream start, block edges, top block, bit patterns
   localparam arxw_pkg::word_type EdgeIndexes[20] = '{
      64'h0, 64'h1, 64'h7, 64'h8, 64'h9, 64'hF, 64'h10,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF8, 64'hFFFF_FFFF_FFFF_FFF9,
      64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFF7,
      64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
      64'h7, 64'h1
   };

   typedef enum logic [1:0] {StallNone, StallLight, StallHalf, StallHeavy} stall_mode_type;
   typedef enum logic [2:0] {
      PickAny, PickRunUp, PickRunDown, PickTop, PickBottom, PickRepeat
   } pick_type;

   typedef struct {
      arxw_pkg::word_type index;
      arxw_pkg::word_type word;
   } awaited_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   arxw_pkg::word_type req_word_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   arxw_pkg::word_type rsp_random_word;

   arxw_pkg::word_type pending_index[$];
   awaited_word_type   awaited_words[$];
   logic               req_taken = 1'b0;
   int                 burst_left = 0;
   int                 gap_left = 0;
   stall_mode_type     stall_mode = StallNone;
   int                 stall_window = 0;
   int                 cycle_count = 0;
   int                 error_count = 0;
   int                 words_sent = 0;
   int                 words_checked = 0;
   int                 stall_cycles = 0;

   arx_counter_random_word_unit #(
      .NUM_ROUNDS(NumRounds)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word_index (req_word_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_random_word(rsp_random_word)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Word at a stream position: build the 8-word block, mix it, pick the word
   function automatic arxw_pkg::word_type stream_word_at(input arxw_pkg::word_type idx);
      arxw_pkg::word_type blk[8];
      arxw_pkg::word_type x;
      arxw_pkg::word_type y;
      int p0;
      int p1;
      int p2;
      int p3;
      for (int k = 0; k < 8; k++) blk[k] = '0;
      blk[0] = {idx[63:3], 3'b000} + 64'd1;
      for (int r = 0; r < NumRounds; r++) begin
         for (int s = 0; s < 4; s++) begin
            p0 = 2 * s;
            p1 = (p0 + 1) % 8;
            p2 = (p0 + 2) % 8;
            p3 = (p0 + 3) % 8;
            x = (blk[p2] ^ blk[p0]) + blk[p1];
            y = (blk[p3] ^ blk[p1]) + blk[p0];
            blk[p2] = (x << RotLow[s]) | (x >> (64 - RotLow[s]));
            blk[p3] = (y << RotHigh[s]) | (y >> (64 - RotHigh[s]));
         end
      end
      return blk[idx[2:0]];
   endfunction

   // Request driver: bursts of transfers with random gaps in between
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_index.size() > 0) begin
            req_valid      <= 1'b1;
            req_word_index <= pending_index.pop_front();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall: modes that change over windows of random length
   always @(negedge clock) begin
      if (stall_window == 0) begin
         stall_mode   = stall_mode_type'($urandom_range(0, 3));
         stall_window = $urandom_range(20, 120);
      end else begin
         stall_window = stall_window - 1;
      end
      case (stall_mode)
         StallNone:  rsp_stall <= 1'b0;
         StallLight: rsp_stall <= ($urandom_range(0, 3) == 0);
         StallHalf:  rsp_stall <= ($urandom_range(0, 1) == 0);
         default:    rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Monitor: record accepted requests, check delivered words in order
   always @(posedge clock) begin
      awaited_word_type head;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            awaited_words.push_back('{index: req_word_index,
                                      word: stream_word_at(req_word_index)});
            words_sent = words_sent + 1;
         end
         if (rsp_valid && rsp_stall) stall_cycles = stall_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               $error("random_word transfer with nothing pending: actual %h", rsp_random_word);
               error_count = error_count + 1;
            end else begin
               head = awaited_words.pop_front();
               words_checked = words_checked + 1;
               if (rsp_random_word !== head.word) begin
                  $error("random_word mismatch at index %h: expected %h, actual %h",
                         head.index, head.word, rsp_random_word);
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Timeout after %0d cycles, %0d words still pending",
                  cycle_count, awaited_words.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      arxw_pkg::word_type base;
      arxw_pkg::word_type last;
      int run_len;
      pick_type pick;

      // Directed: corners, then a block revisited out of order
      foreach (EdgeIndexes[k]) pending_index.push_back(EdgeIndexes[k]);
      for (int k = 23; k >= 19; k--) pending_index.push_back(64'(k));

      // Random: single positions, runs both ways, top and bottom of the stream, repeats
      last = '0;
      while (pending_index.size() < RandomReqs + 25) begin
         pick = pick_type'($urandom_range(0, 5));
         case (pick)
            PickAny: begin
               last = {$urandom, $urandom};
               pending_index.push_back(last);
            end
            PickRunUp, PickRunDown: begin
               base    = {$urandom, $urandom};
               run_len = $urandom_range(1, 16);
               for (int k = 0; k < run_len; k++) begin
                  last = (pick == PickRunUp) ? base + 64'(k) : base - 64'(k);
                  pending_index.push_back(last);
               end
            end
            PickTop: begin
               last = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 31));
               pending_index.push_back(last);
            end
            PickBottom: begin
               last = 64'($urandom_range(0, 63));
               pending_index.push_back(last);
            end
            default: pending_index.push_back(last);
         endcase
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_index.size() != 0 || req_valid || awaited_words.size() != 0)
         @(posedge clock);
      repeat (Latency + 8) @(posedge clock);

      $display("Sent %0d stream positions, checked %0d words, %0d stalled output cycles",
               words_sent, words_checked, stall_cycles);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d errors", error_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
